// ===== hw/rtl/asc_pkg.sv =====
// Shared types and constants for the accelerometer step counter.
// Used by every module under hw/rtl; depends on nothing else.
`timescale 1ns / 1ps

package asc_pkg;

    localparam int AXIS_W    = 16;
    localparam int SUMSQ_W   = 32;
    localparam int MAG_W     = 16;
    localparam int MUL_A_W   = 32;
    localparam int MUL_B_W   = 16;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam int WINDOW_SAMPLES_DEF = 250;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_STEP      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ENERGY        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RUNNING_SPM   = 3'd6;

    // Register reset values
    localparam logic [9:0]  SAMPLE_PERIOD_RST = 10'd20;
    localparam logic [15:0] MIN_STEP_RST      = 16'd250;
    localparam logic [15:0] GRAVITY_RST       = 16'd16384;
    localparam logic [15:0] THRESHOLD_RST     = 16'd3277;
    localparam logic [11:0] STRIDE_RST        = 12'd700;
    localparam logic [9:0]  ENERGY_RST        = 10'd40;
    localparam logic [11:0] RUNNING_SPM_RST   = 12'd140;

    // Activity codes
    localparam logic [1:0] ACT_INACTIVE = 2'd0;
    localparam logic [1:0] ACT_WALKING  = 2'd1;
    localparam logic [1:0] ACT_RUNNING  = 2'd2;

    typedef struct packed {
        logic                     action;
        logic signed [AXIS_W-1:0] accel_x;
        logic signed [AXIS_W-1:0] accel_y;
        logic signed [AXIS_W-1:0] accel_z;
    } sample_t;

    typedef struct packed {
        logic [31:0] step_count;
        logic [43:0] distance_mm;
        logic [41:0] energy_milli;
        logic [1:0]  activity;
        logic        step_seen;
    } result_t;

endpackage

// ===== hw/rtl/asc_mul.sv =====
// Shared 32x16 unsigned multiplier with a registered product.
// Depends on asc_pkg for operand widths.
`timescale 1ns / 1ps

module asc_mul (
    input  logic                          clk,
    input  logic [asc_pkg::MUL_A_W-1:0]   a,
    input  logic [asc_pkg::MUL_B_W-1:0]   b,
    output logic [asc_pkg::MUL_P_W-1:0]   prod_reg
);
    import asc_pkg::*;

    logic [MUL_P_W-1:0] prod_next;

    assign prod_next = MUL_P_W'(a) * MUL_P_W'(b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule

// ===== hw/rtl/asc_sqrt.sv =====
// Bit-serial floor square root: one root bit per cycle, 16-bit root of a 32-bit radicand.
// Depends on asc_pkg for operand widths.
`timescale 1ns / 1ps

module asc_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [asc_pkg::SUMSQ_W-1:0]   radicand,
    output logic                          busy,
    output logic                          done,
    output logic [asc_pkg::MAG_W-1:0]     root
);
    import asc_pkg::*;

    localparam int CNT_W = $clog2(MAG_W);
    localparam int REM_W = MAG_W + 1;
    localparam int TRY_W = MAG_W + 3;

    logic [SUMSQ_W-1:0] rad_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [MAG_W-1:0]   root_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [TRY_W-1:0]   rem_shift;
    logic [TRY_W-1:0]   trial;
    logic               fits;

    assign rem_shift = {rem_reg, rad_reg[SUMSQ_W-1 -: 2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign fits      = (rem_shift >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(MAG_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[SUMSQ_W-3:0], 2'b00};
            if (fits)
            begin
                rem_reg  <= REM_W'(rem_shift - trial);
                root_reg <= {root_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= REM_W'(rem_shift);
                root_reg <= {root_reg[MAG_W-2:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== hw/rtl/accel_step_counter.sv =====
// Top level of the accelerometer step counter: sequencer, step state, registers.
// Depends on asc_pkg, asc_mul and asc_sqrt.
`timescale 1ns / 1ps

// Usage:
//   sample channel (sample_valid/sample_ready/sample): one item per accelerometer
//   sample, or a clear request when action is set. result channel
//   (result_valid/result_ready/result): exactly one item back per sample item.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes,
//   always ready; write only while no sample item is in flight.
// Sequencing:
//   a sample item runs the squares, sum, root, update, distance, energy, latch
//   and done states; a clear item starts at the distance state. One shared
//   32x16 multiplier forms the three squares and later the distance and energy
//   products; a bit-serial root unit finds the magnitude. sample_ready is high
//   only while idle, so a new item waits until the last one leaves the done state.
// Reset:
//   registers take their defaults, all step state and result_valid clear.
// Stall:
//   a finished result sits in the output register; the next item is accepted
//   meanwhile and its result waits in the final state until the port frees up.

module accel_step_counter #(
    parameter int WindowSamples = asc_pkg::WINDOW_SAMPLES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            sample_valid,
    output logic                            sample_ready,
    input  asc_pkg::sample_t                sample,
    output logic                            result_valid,
    input  logic                            result_ready,
    output asc_pkg::result_t                result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [asc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [asc_pkg::CFG_DAT_W-1:0]   cfg_data
);
    import asc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_SQZ,
        ST_SUM,
        ST_ROOT,
        ST_UPDATE,
        ST_DIST,
        ST_ENRG,
        ST_LATCH,
        ST_DONE
    } state_t;

    state_t state_reg;

    // Configuration registers
    logic [9:0]  sample_period_reg;
    logic [15:0] min_step_reg;
    logic [15:0] gravity_reg;
    logic [15:0] threshold_reg;
    logic [11:0] stride_reg;
    logic [9:0]  energy_reg;
    logic [11:0] running_spm_reg;

    // Step state
    logic [31:0] total_steps_reg;
    logic [15:0] since_step_reg;
    logic        prev_above_reg;
    logic [7:0]  window_samples_reg;
    logic [7:0]  window_steps_reg;
    logic [1:0]  activity_reg;
    logic        seen_reg;

    // Per-item payload
    logic [AXIS_W-1:0]  ax_reg;
    logic [AXIS_W-1:0]  ay_reg;
    logic [AXIS_W-1:0]  az_reg;
    logic [SUMSQ_W-1:0] acc_reg;
    logic [43:0]        distance_reg;
    logic [41:0]        energy_milli_reg;

    logic    result_valid_reg;
    result_t result_reg;

    // Shared units
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_prod;
    logic               sqrt_start;
    logic [SUMSQ_W-1:0] sqrt_radicand;
    logic               sqrt_busy;
    logic               sqrt_done;
    logic [MAG_W-1:0]   sqrt_root;

    logic [AXIS_W-1:0] abs_x;
    logic [AXIS_W-1:0] abs_y;
    logic [AXIS_W-1:0] abs_z;

    logic [15:0] motion;
    logic        above;
    logic [16:0] since_sum;
    logic [15:0] since_sat;
    logic        take_step;
    logic [7:0]  window_steps_inc;
    logic [7:0]  window_samples_inc;
    logic [11:0] spm;
    logic [1:0]  activity_class;
    logic        window_end;
    logic        sample_accept;
    logic        result_load;

    asc_mul u_mul (
        .clk      (clk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (mul_prod)
    );

    asc_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sqrt_radicand),
        .busy     (sqrt_busy),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    function automatic logic [AXIS_W-1:0] axis_abs(input logic [AXIS_W-1:0] v);
        axis_abs = v[AXIS_W-1] ? AXIS_W'(~v + 1'b1) : v;
    endfunction

    assign abs_x = axis_abs(sample.accel_x);
    assign abs_y = axis_abs(sample.accel_y);
    assign abs_z = axis_abs(sample.accel_z);

    assign sample_ready  = (state_reg == ST_IDLE);
    assign sample_accept = sample_valid && sample_ready;
    assign cfg_ready     = 1'b1;
    assign result_load   = (state_reg == ST_DONE) && (!result_valid_reg || result_ready);

    // Multiplier operand select: squares first, then the distance and energy products
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQX:
            begin
                mul_a = MUL_A_W'(ax_reg);
                mul_b = ax_reg;
            end
            ST_SQY:
            begin
                mul_a = MUL_A_W'(ay_reg);
                mul_b = ay_reg;
            end
            ST_SQZ:
            begin
                mul_a = MUL_A_W'(az_reg);
                mul_b = az_reg;
            end
            ST_DIST:
            begin
                mul_a = total_steps_reg;
                mul_b = MUL_B_W'(stride_reg);
            end
            ST_ENRG:
            begin
                mul_a = total_steps_reg;
                mul_b = MUL_B_W'(energy_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign sqrt_start    = (state_reg == ST_SUM);
    assign sqrt_radicand = acc_reg + mul_prod[SUMSQ_W-1:0];

    // Step decision on the finished magnitude
    always_comb
    begin
        motion = (sqrt_root >= gravity_reg) ? (sqrt_root - gravity_reg)
                                            : (gravity_reg - sqrt_root);
        above     = (motion > threshold_reg);
        since_sum = {1'b0, since_step_reg} + 17'(sample_period_reg);
        since_sat = since_sum[16] ? 16'hFFFF : since_sum[15:0];
        take_step = above && !prev_above_reg && (since_sat >= min_step_reg);
        window_steps_inc = (take_step && window_steps_reg != 8'hFF)
                         ? window_steps_reg + 8'd1 : window_steps_reg;
        window_samples_inc = window_samples_reg + 8'd1;
        window_end = (window_samples_inc >= 8'(WindowSamples));
        // steps per minute = window steps * 12
        spm = 12'({window_steps_inc, 3'b000}) + 12'({window_steps_inc, 2'b00});
        if (window_steps_inc == 8'd0)
            activity_class = ACT_INACTIVE;
        else if (spm < running_spm_reg)
            activity_class = ACT_WALKING;
        else
            activity_class = ACT_RUNNING;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            sample_period_reg  <= SAMPLE_PERIOD_RST;
            min_step_reg       <= MIN_STEP_RST;
            gravity_reg        <= GRAVITY_RST;
            threshold_reg      <= THRESHOLD_RST;
            stride_reg         <= STRIDE_RST;
            energy_reg         <= ENERGY_RST;
            running_spm_reg    <= RUNNING_SPM_RST;
            total_steps_reg    <= '0;
            since_step_reg     <= '0;
            prev_above_reg     <= 1'b0;
            window_samples_reg <= '0;
            window_steps_reg   <= '0;
            activity_reg       <= ACT_INACTIVE;
            seen_reg           <= 1'b0;
            result_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SAMPLE_PERIOD: sample_period_reg <= cfg_data[9:0];
                    CFG_MIN_STEP:      min_step_reg      <= cfg_data;
                    CFG_GRAVITY:       gravity_reg       <= cfg_data;
                    CFG_THRESHOLD:     threshold_reg     <= cfg_data;
                    CFG_STRIDE:        stride_reg        <= cfg_data[11:0];
                    CFG_ENERGY:        energy_reg        <= cfg_data[9:0];
                    CFG_RUNNING_SPM:   running_spm_reg   <= cfg_data[11:0];
                    default: ;
                endcase
            end

            if (result_load)
                result_valid_reg <= 1'b1;
            else if (result_valid_reg && result_ready)
                result_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (sample_accept)
                    begin
                        if (sample.action)
                        begin
                            // drop all step state, keep registers
                            total_steps_reg    <= '0;
                            since_step_reg     <= '0;
                            prev_above_reg     <= 1'b0;
                            window_samples_reg <= '0;
                            window_steps_reg   <= '0;
                            activity_reg       <= ACT_INACTIVE;
                            seen_reg           <= 1'b0;
                            state_reg          <= ST_DIST;
                        end
                        else
                        begin
                            state_reg <= ST_SQX;
                        end
                    end
                end
                ST_SQX:    state_reg <= ST_SQY;
                ST_SQY:    state_reg <= ST_SQZ;
                ST_SQZ:    state_reg <= ST_SUM;
                ST_SUM:    state_reg <= ST_ROOT;
                ST_ROOT:
                begin
                    if (sqrt_done)
                        state_reg <= ST_UPDATE;
                end
                ST_UPDATE:
                begin
                    since_step_reg  <= take_step ? 16'd0 : since_sat;
                    total_steps_reg <= total_steps_reg + 32'(take_step);
                    prev_above_reg  <= above;
                    seen_reg        <= take_step;
                    if (window_end)
                    begin
                        activity_reg       <= activity_class;
                        window_samples_reg <= '0;
                        window_steps_reg   <= '0;
                    end
                    else
                    begin
                        window_samples_reg <= window_samples_inc;
                        window_steps_reg   <= window_steps_inc;
                    end
                    state_reg <= ST_DIST;
                end
                ST_DIST:   state_reg <= ST_ENRG;
                ST_ENRG:   state_reg <= ST_LATCH;
                ST_LATCH:  state_reg <= ST_DONE;
                ST_DONE:
                begin
                    // hold until the output register is free
                    if (result_load)
                        state_reg <= ST_IDLE;
                end
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (sample_accept)
        begin
            ax_reg <= abs_x;
            ay_reg <= abs_y;
            az_reg <= abs_z;
        end
        if (state_reg == ST_SQY)
            acc_reg <= mul_prod[SUMSQ_W-1:0];
        else if (state_reg == ST_SQZ)
            acc_reg <= acc_reg + mul_prod[SUMSQ_W-1:0];
        if (state_reg == ST_ENRG)
            distance_reg <= mul_prod[43:0];
        if (state_reg == ST_LATCH)
            energy_milli_reg <= mul_prod[41:0];
        if (result_load)
        begin
            result_reg.step_count   <= total_steps_reg;
            result_reg.distance_mm  <= distance_reg;
            result_reg.energy_milli <= energy_milli_reg;
            result_reg.activity     <= activity_reg;
            result_reg.step_seen    <= seen_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        sample_accept |=> !sample_ready
    ) else $error("sample_ready high right after an accepted item");

    a_root_in_root_state: assert property (
        @(posedge clk) disable iff (!rst_n)
        (sqrt_done || sqrt_busy) |-> (state_reg == ST_ROOT)
    ) else $error("root unit active outside the root state");

    a_window_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        window_samples_reg < 8'(WindowSamples)
    ) else $error("window sample count reached the window length");

    a_step_resets_timer: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_load && seen_reg) |-> (since_step_reg == 16'd0)
    ) else $error("counted step without a cleared step timer");

    a_activity_code: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (result_reg.activity != 2'd3)
    ) else $error("activity code out of range");

endmodule

// ===== bench/accel_step_counter_tb.sv =====
// Self-checking bench for accel_step_counter: directed edge cases, then random traffic.
// Predicts each result in-bench and checks it field by field. Depends on asc_pkg and the RTL.
`timescale 1ns / 1ps

module accel_step_counter_tb;

    import asc_pkg::*;

    localparam int WINDOW       = WINDOW_SAMPLES_DEF;
    localparam int ITEM_TARGET  = 1650;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PRINT_CAP    = 50;

    // No register sits at this index; writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    logic                 clk;
    logic                 rst_n;
    logic                 sample_valid;
    logic                 sample_ready;
    sample_t              sample;
    logic                 result_valid;
    logic                 result_ready;
    result_t              result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    // Bench copy of the registers
    logic [9:0]  cfg_period    = SAMPLE_PERIOD_RST;
    logic [15:0] cfg_min_gap   = MIN_STEP_RST;
    logic [15:0] cfg_gravity   = GRAVITY_RST;
    logic [15:0] cfg_threshold = THRESHOLD_RST;
    logic [11:0] cfg_stride    = STRIDE_RST;
    logic [9:0]  cfg_energy    = ENERGY_RST;
    logic [11:0] cfg_run_spm   = RUNNING_SPM_RST;

    // Bench copy of the pedometer state
    logic [31:0] steps_total  = '0;
    int          since_ms     = 0;
    bit          was_above    = 0;
    int          win_count    = 0;
    int          win_steps    = 0;
    logic [1:0]  activity_now = ACT_INACTIVE;

    result_t tally_q[$];
    result_t due_tally;

    int  mismatches    = 0;
    int  items_sent    = 0;
    int  clears_sent   = 0;
    int  steps_checked = 0;
    int  act_hits[3]   = '{0, 0, 0};
    int  cycle_count   = 0;
    bit  steady_source = 0;
    bit  steady_sink   = 0;

    accel_step_counter #(
        .WindowSamples(WINDOW)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: watchdog expired after %0d cycles", $time, cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int axis_mag(input logic signed [15:0] v);
        int w;
        w = v;
        return (w < 0) ? -w : w;
    endfunction

    // Advance the bench state by one item and return the tally it should report
    function automatic result_t next_tally(input sample_t s);
        result_t     r;
        logic [63:0] sumsq;
        logic [63:0] trial;
        logic [31:0] root;
        int          motion;
        bit          above;
        bit          seen;
        seen = 0;
        if (s.action)
        begin
            steps_total  = '0;
            since_ms     = 0;
            was_above    = 0;
            win_count    = 0;
            win_steps    = 0;
            activity_now = ACT_INACTIVE;
        end
        else
        begin
            sumsq = 64'(axis_mag(s.accel_x)) * 64'(axis_mag(s.accel_x))
                  + 64'(axis_mag(s.accel_y)) * 64'(axis_mag(s.accel_y))
                  + 64'(axis_mag(s.accel_z)) * 64'(axis_mag(s.accel_z));
            root = '0;
            for (int b = 15; b >= 0; b--)
            begin
                trial = 64'(root | (32'd1 << b));
                if (trial * trial <= sumsq)
                    root = trial[31:0];
            end
            motion = (int'(root) >= int'(cfg_gravity)) ? int'(root) - int'(cfg_gravity)
                                                       : int'(cfg_gravity) - int'(root);
            above = (motion > int'(cfg_threshold));

            since_ms = since_ms + int'(cfg_period);
            if (since_ms > 65535)
                since_ms = 65535;
            if (above && !was_above && since_ms >= int'(cfg_min_gap))
            begin
                steps_total = steps_total + 32'd1;
                if (win_steps < 255)
                    win_steps++;
                since_ms = 0;
                seen = 1;
            end
            was_above = above;

            win_count = (win_count + 1) & 255;
            if (win_count >= WINDOW)
            begin
                if (win_steps == 0)
                    activity_now = ACT_INACTIVE;
                else if (win_steps * 12 < int'(cfg_run_spm))
                    activity_now = ACT_WALKING;
                else
                    activity_now = ACT_RUNNING;
                win_count = 0;
                win_steps = 0;
            end
        end
        r.step_count   = steps_total;
        r.distance_mm  = 44'({32'd0, steps_total} * {52'd0, cfg_stride});
        r.energy_milli = 42'({32'd0, steps_total} * {54'd0, cfg_energy});
        r.activity     = activity_now;
        r.step_seen    = seen;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= PRINT_CAP)
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (tally_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: result item with none pending, got step_count %0d",
                         $time, result.step_count);
            end
            else
            begin
                due_tally = tally_q.pop_front();
                check_field("step_count", due_tally.step_count, result.step_count);
                check_field("distance_mm", due_tally.distance_mm, result.distance_mm);
                check_field("energy_milli", due_tally.energy_milli, result.energy_milli);
                check_field("activity", due_tally.activity, result.activity);
                check_field("step_seen", due_tally.step_seen, result.step_seen);
                steps_checked += due_tally.step_seen;
                if (due_tally.activity <= ACT_RUNNING)
                    act_hits[due_tally.activity]++;
            end
        end
    end

    // Result side: mostly ready, short stalls, now and then a long one
    initial
    begin
        int stall_left;
        int roll;
        stall_left   = 0;
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                result_ready = 1'b0;
                stall_left--;
            end
            else
            begin
                result_ready = 1'b1;
                if (!steady_sink)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 10)
                        stall_left = $urandom_range(1, 3);
                    else if (roll < 13)
                        stall_left = $urandom_range(4, 12);
                    else if (roll < 15)
                        stall_left = $urandom_range(20, 50);
                end
            end
        end
    end

    function automatic int source_gap();
        int roll;
        if (steady_source)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic sample_t make_item(input bit act, input int x, input int y, input int z);
        sample_t s;
        s.action  = act;
        s.accel_x = 16'(x);
        s.accel_y = 16'(y);
        s.accel_z = 16'(z);
        return s;
    endfunction

    // Point the vector along a random axis (plus jitter), or over all three axes above 32000
    function automatic sample_t shaped_sample(input int mag);
        int a[3];
        int lead;
        if (mag < 0)
            mag = 0;
        if (mag > 56000)
            mag = 56000;
        if (mag <= 32000)
        begin
            lead = $urandom_range(0, 2);
            for (int i = 0; i < 3; i++)
                a[i] = (i == lead) ? mag : $urandom_range(0, 300);
        end
        else
        begin
            for (int i = 0; i < 3; i++)
                a[i] = mag * 577 / 1000;
        end
        for (int i = 0; i < 3; i++)
            if ($urandom_range(0, 1))
                a[i] = -a[i];
        return make_item(1'b0, a[0], a[1], a[2]);
    endfunction

    function automatic sample_t quiet_sample();
        int half;
        half = int'(cfg_threshold) / 2;
        return shaped_sample(int'(cfg_gravity) + int'($urandom_range(0, 2 * half)) - half);
    endfunction

    function automatic sample_t peak_sample();
        int bump;
        bump = int'(cfg_threshold) + int'($urandom_range(1, 3000));
        if ($urandom_range(0, 3) == 0 && int'(cfg_gravity) > bump)
            return shaped_sample(int'(cfg_gravity) - bump);
        return shaped_sample(int'(cfg_gravity) + bump);
    endfunction

    function automatic sample_t raw_sample(input bit act);
        return make_item(act, int'($urandom_range(0, 65535)) - 32768,
                         int'($urandom_range(0, 65535)) - 32768,
                         int'($urandom_range(0, 65535)) - 32768);
    endfunction

    function automatic sample_t corner_sample();
        int corners[7] = '{-32768, -16384, -1, 0, 1, 16384, 32767};
        int pick[3];
        for (int i = 0; i < 3; i++)
            pick[i] = corners[$urandom_range(0, 6)];
        return make_item(1'b0, pick[0], pick[1], pick[2]);
    endfunction

    function automatic logic [15:0] plausible_value(input logic [CFG_IDX_W-1:0] idx);
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom_range(0, 65535));
        case (idx)
            CFG_SAMPLE_PERIOD: return 16'($urandom_range(5, 50));
            CFG_MIN_STEP:      return 16'($urandom_range(0, 600));
            CFG_GRAVITY:       return 16'($urandom_range(15000, 18000));
            CFG_THRESHOLD:     return 16'($urandom_range(1000, 6000));
            CFG_STRIDE:        return 16'($urandom_range(300, 1200));
            CFG_ENERGY:        return 16'($urandom_range(20, 100));
            CFG_RUNNING_SPM:   return 16'($urandom_range(60, 300));
            default:           return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_item(input sample_t item);
        int gap;
        gap = source_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            sample_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample       = item;
        sample_valid = 1'b1;
        do @(posedge clk); while (!sample_ready);
        tally_q.push_back(next_tally(item));
        items_sent++;
        if (item.action)
            clears_sent++;
    endtask

    // Drop valid and wait until every pending result has come back
    task automatic settle();
        @(negedge clk);
        sample_valid = 1'b0;
        while (tally_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_SAMPLE_PERIOD: cfg_period    = value[9:0];
            CFG_MIN_STEP:      cfg_min_gap   = value;
            CFG_GRAVITY:       cfg_gravity   = value;
            CFG_THRESHOLD:     cfg_threshold = value;
            CFG_STRIDE:        cfg_stride    = value[11:0];
            CFG_ENERGY:        cfg_energy    = value[9:0];
            CFG_RUNNING_SPM:   cfg_run_spm   = value[11:0];
            default:           ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic walk(input int strides, input int max_rest);
        repeat (strides)
        begin
            repeat ($urandom_range(0, max_rest)) send_item(quiet_sample());
            repeat ($urandom_range(1, 3)) send_item(peak_sample());
        end
    endtask

    // Send items until the activity window closes
    task automatic fill_window(input bit stepping);
        do
        begin
            if (stepping && $urandom_range(0, 2) == 0)
                send_item(peak_sample());
            else
                send_item(quiet_sample());
        end
        while (win_count != 0);
    endtask

    task automatic test_directed_edges();
        send_item(make_item(1'b0, 0, 0, 0));
        send_item(make_item(1'b0, -32768, -32768, -32768));
        send_item(make_item(1'b0, 32767, 32767, 32767));
        send_item(make_item(1'b0, -32768, 32767, -1));
        send_item(make_item(1'b0, 1, -1, 0));
        repeat (4) send_item(make_item(1'b0, 0, 0, 16384));
        repeat (4) send_item(make_item(1'b0, 0, -16384, 0));
        // motion equal to the threshold is not above it; one more unit is
        send_item(make_item(1'b0, 0, 0, 16384 + 3277));
        send_item(make_item(1'b0, 0, 0, 16384 + 3278));
        // second crossing comes too soon after the counted step
        send_item(make_item(1'b0, 0, 0, 16384));
        send_item(make_item(1'b0, 0, 0, -(16384 - 3278)));
        send_item(make_item(1'b1, -32768, 32767, -32768));
        send_item(make_item(1'b0, 0, 0, 0));
        settle();
    endtask

    task automatic test_step_timer();
        // longest period with the longest spacing: the timer must pin at its top
        write_reg(CFG_SAMPLE_PERIOD, 16'hFFFF);
        write_reg(CFG_MIN_STEP, 16'hFFFF);
        repeat (70) send_item(quiet_sample());
        send_item(peak_sample());
        repeat (20) send_item(quiet_sample());
        send_item(peak_sample());
        settle();
        // frozen timer: every crossing counts with no spacing, none with any
        write_reg(CFG_SAMPLE_PERIOD, 16'd0);
        write_reg(CFG_MIN_STEP, 16'd0);
        walk(6, 3);
        settle();
        write_reg(CFG_MIN_STEP, 16'd1);
        walk(3, 3);
        settle();
        write_reg(CFG_SAMPLE_PERIOD, 16'(SAMPLE_PERIOD_RST));
        write_reg(CFG_MIN_STEP, MIN_STEP_RST);
    endtask

    task automatic test_register_extremes();
        logic [15:0] lows[7]     = '{16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
        logic [15:0] defaults[7] = '{16'(SAMPLE_PERIOD_RST), MIN_STEP_RST, GRAVITY_RST,
                                     THRESHOLD_RST, 16'(STRIDE_RST), 16'(ENERGY_RST),
                                     16'(RUNNING_SPM_RST)};
        for (int i = 0; i < 7; i++)
        begin
            write_reg(CFG_IDX_W'(i), lows[i]);
            walk(3, 4);
            settle();
            write_reg(CFG_IDX_W'(i), 16'hFFFF);
            walk(3, 4);
            settle();
            write_reg(CFG_IDX_W'(i), defaults[i]);
        end
        write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
        walk(2, 4);
        settle();
    endtask

    task automatic test_activity_windows();
        write_reg(CFG_SAMPLE_PERIOD, 16'd20);
        write_reg(CFG_MIN_STEP, 16'd0);
        send_item(raw_sample(1'b1));
        settle();
        // top rate threshold: any stepping window reads as walking
        write_reg(CFG_RUNNING_SPM, 16'hFFFF);
        fill_window(1'b1);
        settle();
        // zero rate threshold: any stepping window reads as running; no idling here
        write_reg(CFG_RUNNING_SPM, 16'd0);
        steady_source = 1;
        steady_sink   = 1;
        fill_window(1'b1);
        settle();
        steady_source = 0;
        steady_sink   = 0;
        fill_window(1'b0);
        settle();
        write_reg(CFG_RUNNING_SPM, 16'(RUNNING_SPM_RST));
        write_reg(CFG_MIN_STEP, MIN_STEP_RST);
    endtask

    task automatic test_random_traffic();
        int                   roll;
        int                   phase_end;
        logic [CFG_IDX_W-1:0] reg_pick;
        while (items_sent < ITEM_TARGET)
        begin
            settle();
            repeat ($urandom_range(0, 3))
            begin
                reg_pick = CFG_IDX_W'($urandom_range(0, 6));
                write_reg(reg_pick, plausible_value(reg_pick));
            end
            steady_source = ($urandom_range(0, 3) == 0);
            steady_sink   = ($urandom_range(0, 3) == 0);
            phase_end     = items_sent + $urandom_range(60, 120);
            while (items_sent < phase_end)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    walk($urandom_range(1, 4), $urandom_range(0, 15));
                else if (roll < 82)
                    send_item(raw_sample(1'b0));
                else if (roll < 90)
                    send_item(corner_sample());
                else if (roll < 93)
                    send_item(raw_sample(1'b1));
                else
                    send_item(quiet_sample());
            end
        end
        steady_source = 0;
        steady_sink   = 0;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_SAMPLE_PERIOD;
        cfg_data     = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_edges();
        test_step_timer();
        test_register_extremes();
        test_activity_windows();
        test_random_traffic();

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Run covered %0d items, %0d of them clears, with %0d counted steps.",
                 items_sent, clears_sent, steps_checked);
        $display("Activity reported: inactive %0d, walking %0d, running %0d times.",
                 act_hits[0], act_hits[1], act_hits[2]);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/asc_pkg.sv
hw/rtl/asc_mul.sv
hw/rtl/asc_sqrt.sv
hw/rtl/accel_step_counter.sv
bench/accel_step_counter_tb.sv
